// ===== rtl/dupdet_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dupdet_pkg
// Shared widths and defaults for the duplicate detector.
// ----------------------------------------------------------------------------
package dupdet_pkg;

    localparam int DATA_W           = 32;    // width of one element
    localparam int MAX_ELEMENTS_DEF = 1024;  // default store depth
    localparam int OUT_TDATA_W      = 8;     // result tdata, padded to a byte

    // result tdata bit positions
    localparam int RES_DUP_BIT = 0;
    localparam int RES_OVF_BIT = 1;

endpackage

// ===== rtl/dupdet_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dupdet_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dupdet_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/duplicate_detect_by_merge_sort.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duplicate_detect_by_merge_sort
// Collects a set of signed values, merge-sorts it between two RAMs and reports
// whether any value occurs twice.
// ----------------------------------------------------------------------------
// Elements are taken one transfer per cycle until the transfer with tlast set.
// The input then stalls while the set of n stored elements is sorted with a
// bottom-up merge sort that ping-pongs between two single-read-port RAMs:
// ceil(log2 n) passes, in which every merged element costs one write plus one
// refill read of the source RAM. A final scan compares neighbors, after which
// the one result transfer is queued in an output register and loading resumes.
// Elements beyond MAX_ELEMENTS are dropped and flagged as overflow in the result.
// ----------------------------------------------------------------------------
module duplicate_detect_by_merge_sort #(
    parameter int MAX_ELEMENTS = dupdet_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dupdet_pkg::DATA_W-1:0]       s_tdata,  // [31:0] value
    input  logic                                s_tlast,  // last_element
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dupdet_pkg::OUT_TDATA_W-1:0]  m_tdata   // [0] has_duplicate,
                                                          // [1] overflow, [7:2] 0
);

    import dupdet_pkg::*;

    localparam int AW    = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int PW    = CNT_W + 2;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PASS,
        ST_SEG,
        ST_LDA,
        ST_LDB,
        ST_MERGE,
        ST_REFA,
        ST_REFB,
        ST_CHK,
        ST_DONE
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              ovf_reg;
    logic              src_sel_reg;    // RAM holding the current source run
    logic [PW-1:0]     width_reg;
    logic [PW-1:0]     base_reg;
    logic [CNT_W-1:0]  mid_reg;
    logic [CNT_W-1:0]  end_reg;
    logic [CNT_W-1:0]  p_reg;
    logic [CNT_W-1:0]  q_reg;
    logic [CNT_W-1:0]  k_reg;
    logic [DATA_W-1:0] a_reg;
    logic [DATA_W-1:0] b_reg;
    logic [DATA_W-1:0] prev_reg;
    logic [AW-1:0]     idx_reg;
    logic              dup_reg;
    logic              m_valid_reg;
    logic              m_dup_reg;
    logic              m_ovf_reg;

    // RAM ports
    logic              we0, we1;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data0, rd_data1, rd_data;

    // segment bounds and merge decision
    logic [PW-1:0]     sum_mid, sum_end, count_ext;
    logic [CNT_W-1:0]  seg_mid, seg_end;
    logic              p_ok, q_ok, take_a, seg_done;
    logic              s_fire, mem_full, chk_hit, chk_last;

    assign s_fire    = s_tvalid && s_tready;
    assign mem_full  = (count_reg == CNT_W'(MAX_ELEMENTS));
    assign count_ext = PW'(count_reg);
    assign sum_mid   = base_reg + width_reg;
    assign sum_end   = base_reg + (width_reg << 1);
    assign seg_mid   = (sum_mid > count_ext) ? count_reg : sum_mid[CNT_W-1:0];
    assign seg_end   = (sum_end > count_ext) ? count_reg : sum_end[CNT_W-1:0];

    assign p_ok     = (p_reg < mid_reg);
    assign q_ok     = (q_reg < end_reg);
    assign take_a   = p_ok && (!q_ok || ($signed(a_reg) <= $signed(b_reg)));
    assign seg_done = !p_ok && !q_ok;

    assign rd_data  = src_sel_reg ? rd_data1 : rd_data0;
    assign chk_hit  = (idx_reg != '0) && (rd_data == prev_reg);
    assign chk_last = (CNT_W'(idx_reg) == count_reg - CNT_W'(1));

    always_comb begin
        we0     = 1'b0;
        we1     = 1'b0;
        wr_addr = k_reg[AW-1:0];
        wr_data = take_a ? a_reg : b_reg;
        rd_addr = '0;
        case (state_reg)
            ST_LOAD: begin
                wr_addr = count_reg[AW-1:0];
                wr_data = s_tdata;
                we0     = s_fire && !mem_full;
            end
            ST_SEG: begin
                rd_addr = base_reg[AW-1:0];
            end
            ST_LDA: begin
                rd_addr = q_reg[AW-1:0];
            end
            ST_MERGE: begin
                // merge output goes to the RAM that is not the source
                we0     = !seg_done && src_sel_reg;
                we1     = !seg_done && !src_sel_reg;
                rd_addr = take_a ? (p_reg[AW-1:0] + AW'(1)) : (q_reg[AW-1:0] + AW'(1));
            end
            ST_CHK: begin
                rd_addr = idx_reg + AW'(1);
            end
            default: begin
                rd_addr = '0;
            end
        endcase
    end

    dupdet_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMENTS)) u_ram0 (
        .aclk    (aclk),
        .wr_en   (we0),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data0)
    );

    dupdet_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMENTS)) u_ram1 (
        .aclk    (aclk),
        .wr_en   (we1),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data1)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            src_sel_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // in ST_DONE the result register is reloaded instead
            if (m_valid_reg && m_tready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_LOAD: begin
                    if (s_fire) begin
                        if (mem_full) begin
                            ovf_reg <= 1'b1;
                        end else begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        if (s_tlast) begin
                            width_reg   <= PW'(1);
                            src_sel_reg <= 1'b0;
                            state_reg   <= ST_PASS;
                        end
                    end
                end
                ST_PASS: begin
                    if (width_reg >= count_ext) begin
                        // sorted; rd_addr 0 was issued this cycle
                        idx_reg   <= '0;
                        state_reg <= ST_CHK;
                    end else begin
                        base_reg  <= '0;
                        state_reg <= ST_SEG;
                    end
                end
                ST_SEG: begin
                    if (base_reg >= count_ext) begin
                        src_sel_reg <= !src_sel_reg;
                        width_reg   <= width_reg << 1;
                        state_reg   <= ST_PASS;
                    end else begin
                        mid_reg   <= seg_mid;
                        end_reg   <= seg_end;
                        p_reg     <= base_reg[CNT_W-1:0];
                        q_reg     <= seg_mid;
                        k_reg     <= base_reg[CNT_W-1:0];
                        state_reg <= ST_LDA;
                    end
                end
                ST_LDA: begin
                    a_reg     <= rd_data;
                    state_reg <= ST_LDB;
                end
                ST_LDB: begin
                    b_reg     <= rd_data;
                    state_reg <= ST_MERGE;
                end
                ST_MERGE: begin
                    if (seg_done) begin
                        base_reg  <= PW'(end_reg);
                        state_reg <= ST_SEG;
                    end else begin
                        k_reg <= k_reg + CNT_W'(1);
                        if (take_a) begin
                            p_reg     <= p_reg + CNT_W'(1);
                            state_reg <= ST_REFA;
                        end else begin
                            q_reg     <= q_reg + CNT_W'(1);
                            state_reg <= ST_REFB;
                        end
                    end
                end
                ST_REFA: begin
                    a_reg     <= rd_data;
                    state_reg <= ST_MERGE;
                end
                ST_REFB: begin
                    b_reg     <= rd_data;
                    state_reg <= ST_MERGE;
                end
                ST_CHK: begin
                    prev_reg <= rd_data;
                    idx_reg  <= idx_reg + AW'(1);
                    if (chk_hit || chk_last) begin
                        dup_reg   <= chk_hit;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // wait until the result register is free
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_dup_reg   <= dup_reg;
                        m_ovf_reg   <= ovf_reg;
                        count_reg   <= '0;
                        ovf_reg     <= 1'b0;
                        state_reg   <= ST_LOAD;
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        m_tdata              = '0;
        m_tdata[RES_DUP_BIT] = m_dup_reg;
        m_tdata[RES_OVF_BIT] = m_ovf_reg;
    end

endmodule

// ===== rtl/dupdet_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dupdet_checker
// Port-level checks for the duplicate detector, bound to the top level.
// ----------------------------------------------------------------------------
module dupdet_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                s_tlast,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [dupdet_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    import dupdet_pkg::*;

    // a stalled result holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    // padding bits of the result stay zero
    a_m_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_TDATA_W-1:RES_OVF_BIT+1] == '0))
        else $error("result padding bits not zero");

    // closing transfer of a set stops loading for the sort
    a_last_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still ready after last transfer");

    // a new result only appears while the input is stalled
    a_res_timing: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result produced while loading");

endmodule

bind duplicate_detect_by_merge_sort dupdet_checker u_dupdet_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/sv/duplicate_detect_by_merge_sort_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duplicate_detect_by_merge_sort_tb
// Streams sets of signed 32-bit values into the duplicate detector and checks
// each set's verdict against a scoreboard that keeps its own copy of the set.
// The sets are short directed corner cases, full and overflowing stores, and
// random sets of mixed shape. Both stream sides idle at varying rates.
// ----------------------------------------------------------------------------
module duplicate_detect_by_merge_sort_tb;

    import dupdet_pkg::*;

    localparam int STORE_DEPTH = MAX_ELEMENTS_DEF;
    localparam int ITEMS_PER_PHASE = 250;
    localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic dup;
        logic ovf;
    } verdict_t;

    // Scoreboard: mirrors the element store and queues one verdict per set.
    class dup_scoreboard;
        int            depth;
        int            set_vals[$];
        bit            set_ovf;
        verdict_t      verdict_q[$];
        int            errors;
        int            sets_done;
        int            dup_sets;
        int            ovf_sets;

        function new(int store_depth);
            depth     = store_depth;
            set_ovf   = 1'b0;
            errors    = 0;
            sets_done = 0;
            dup_sets  = 0;
            ovf_sets  = 0;
        endfunction

        function void note_input(logic [DATA_W-1:0] v, bit last);
            verdict_t exp_v;
            int       i;
            if (set_vals.size() < depth) begin
                set_vals.push_back(int'(v));
            end else begin
                set_ovf = 1'b1;
            end
            if (last) begin
                // signed ascending order, then compare neighbors
                set_vals.sort();
                exp_v.dup = 1'b0;
                exp_v.ovf = set_ovf;
                for (i = 1; i < set_vals.size(); i++) begin
                    if (set_vals[i-1] == set_vals[i]) begin
                        exp_v.dup = 1'b1;
                    end
                end
                verdict_q.push_back(exp_v);
                if (exp_v.dup) dup_sets++;
                if (exp_v.ovf) ovf_sets++;
                set_vals.delete();
                set_ovf = 1'b0;
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] tdata);
            verdict_t exp_v;
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result transfer, actual tdata %0h", $time, tdata);
                errors++;
                return;
            end
            exp_v = verdict_q.pop_front();
            sets_done++;
            if (tdata[RES_DUP_BIT] !== exp_v.dup) begin
                $display("%0t: has_duplicate mismatch: expected %0b, actual %0b",
                         $time, exp_v.dup, tdata[RES_DUP_BIT]);
                errors++;
            end
            if (tdata[RES_OVF_BIT] !== exp_v.ovf) begin
                $display("%0t: overflow mismatch: expected %0b, actual %0b",
                         $time, exp_v.ovf, tdata[RES_OVF_BIT]);
                errors++;
            end
            if (tdata[OUT_TDATA_W-1:2] !== '0) begin
                $display("%0t: padding mismatch: expected 0, actual %0h",
                         $time, tdata[OUT_TDATA_W-1:2]);
                errors++;
            end
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [DATA_W-1:0]       s_tdata;   // [31:0] value
    logic                    s_tlast;   // last_element
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;   // [0] has_duplicate, [1] overflow, [7:2] 0

    dup_scoreboard           sb;
    logic [DATA_W-1:0]       set_buf[$];
    int                      send_idle_pct;
    int                      recv_idle_pct;
    bit                      send_burst;
    int                      recv_burst_left;
    int                      items_sent;

    duplicate_detect_by_merge_sort #(
        .MAX_ELEMENTS(STORE_DEPTH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Result side: random back-pressure with occasional full-rate stretches.
    always @(negedge aclk) begin
        if (recv_burst_left > 0) begin
            m_tready <= 1'b1;
            recv_burst_left <= recv_burst_left - 1;
        end else if ($urandom_range(0, 199) == 0) begin
            m_tready <= 1'b1;
            recv_burst_left <= 40;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input logic [DATA_W-1:0] v, input bit last);
        while (!send_burst && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(v, last);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_set();
        int i;
        for (i = 0; i < set_buf.size(); i++) begin
            send_item(set_buf[i], i == set_buf.size() - 1);
        end
    endtask

    // Distinct values: an odd multiplier is a bijection mod 2^32.
    task automatic fill_distinct(input int n);
        logic [DATA_W-1:0] base;
        int                i;
        base = $urandom;
        set_buf.delete();
        for (i = 0; i < n; i++) begin
            set_buf.push_back(base + DATA_W'(i) * 32'h9E37_79B1);
        end
    endtask

    task automatic build_random_set();
        logic [DATA_W-1:0] corner_vals[7];
        int                n;
        int                mode;
        int                i;
        corner_vals = '{VAL_MIN, VAL_MIN + 1, 32'hFFFF_FFFF, 32'h0, 32'h1,
                        VAL_MAX - 1, VAL_MAX};
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        mode = $urandom_range(0, 3);
        set_buf.delete();
        case (mode)
            0: begin
                for (i = 0; i < n; i++) set_buf.push_back($urandom);
            end
            1: begin
                // narrow pool around zero: duplicates are likely
                for (i = 0; i < n; i++) set_buf.push_back(DATA_W'($urandom_range(0, 8)) - 4);
            end
            2: begin
                fill_distinct(n);
                if (n > 1 && $urandom_range(0, 1) == 1) begin
                    set_buf[$urandom_range(0, n - 1)] = set_buf[$urandom_range(0, n - 1)];
                end
            end
            default: begin
                for (i = 0; i < n; i++) set_buf.push_back(corner_vals[$urandom_range(0, 6)]);
            end
        endcase
    endtask

    task automatic run_random_phase();
        int start_items;
        start_items = items_sent;
        while (items_sent - start_items < ITEMS_PER_PHASE) begin
            send_burst = ($urandom_range(0, 4) == 0);
            build_random_set();
            send_set();
        end
        send_burst = 1'b0;
    endtask

    initial begin
        sb = new(STORE_DEPTH);
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        send_burst = 1'b0;
        recv_burst_left = 0;
        items_sent = 0;
        send_idle_pct = 32;
        recv_idle_pct = 78;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed corner sets
        set_buf = '{VAL_MIN};                                 send_set();
        set_buf = '{VAL_MAX, VAL_MIN};                        send_set();
        set_buf = '{VAL_MIN, VAL_MIN};                        send_set();
        set_buf = '{32'h0, 32'hFFFF_FFFF, 32'h1, VAL_MAX, VAL_MAX}; send_set();
        set_buf = '{32'hFFFF_FFFF, 32'h0};                    send_set();
        set_buf = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555}; send_set();
        set_buf = '{32'hAAAA_AAAA, 32'h5555_5555, VAL_MIN, 32'h0}; send_set();

        // exactly full store, no overflow
        fill_distinct(STORE_DEPTH);
        send_set();
        // one past full: the tlast element is dropped, so its copy is not a duplicate
        fill_distinct(STORE_DEPTH);
        set_buf.push_back(set_buf[7]);
        send_set();
        // several past full with a duplicate among stored elements
        fill_distinct(STORE_DEPTH);
        set_buf[1000] = set_buf[3];
        repeat (6) set_buf.push_back($urandom);
        send_set();

        run_random_phase();
        send_idle_pct = 78;
        recv_idle_pct = 32;
        run_random_phase();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase();

        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (sb.verdict_q.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);

        $display("Checked %0d sets from %0d input transfers: %0d with duplicates, %0d overflowed.",
                 sb.sets_done, items_sent, sb.dup_sets, sb.ovf_sets);
        if (sb.errors == 0) begin
            $display("duplicate_detect_by_merge_sort_tb OK");
        end else begin
            $display("duplicate_detect_by_merge_sort_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("%0t: timeout", $time);
        $display("duplicate_detect_by_merge_sort_tb NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/dupdet_pkg.sv
rtl/dupdet_ram.sv
rtl/duplicate_detect_by_merge_sort.sv
rtl/dupdet_checker.sv
tb/sv/duplicate_detect_by_merge_sort_tb.sv
